// ===== src/hcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcb_pkg;

    localparam int DEF_MAX_SYMBOLS = 16;
    localparam int DEF_FREQ_BITS   = 16;

    localparam int FREQ_IN_W   = 16;
    localparam int SYMBOL_W    = 8;
    localparam int CODE_BITS_W = 15;
    localparam int CODE_LEN_W  = 4;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

endpackage

`default_nettype wire

// ===== src/hcb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/huffman_code_builder.sv =====
// huffman code builder
// input words on s_*: frequency and symbol in s_tdata, s_tlast closes the set.
// words beyond MAX_SYMBOLS are dropped and flag overflow for the whole run.
// s_tready is high only while loading; after the closing word the block
// builds the tree and then sends one word per loaded symbol on m_*, in load
// order, with m_tlast on the final one and overflow in m_tuser.
// tree build: n-1 merge passes over a single slot memory read port; each pass
// has one read and one compare state per live slot, then the merge A and merge B
// write states.
// code readout: per symbol a start state, then a check and an evaluate state per
// tree level walked through the node memory, then the output handshake.
// the output word is held in a register until m_tready; while it stalls the
// sequencer waits and nothing is lost. loading resumes after the last word.
// reset (aresetn low, synchronous) empties the set and returns to loading;
// memories need no clearing since every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    parameter int FREQ_BITS   = DEF_FREQ_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // frequency[15:0], symbol[23:16]
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // symbol_out, code_bits, code_length, zero pad
    output logic                      m_tuser,   // overflow
    output logic                      m_tlast
);

    localparam int IDX_W  = $clog2(MAX_SYMBOLS);
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int NODES  = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int WW     = FREQ_BITS + $clog2(MAX_SYMBOLS);
    localparam int SLOT_W = NODE_W + WW;

    typedef enum logic [2:0] {
        ST_LOAD, ST_SCAN_RD, ST_SCAN_CMP, ST_MERGE_A, ST_MERGE_B,
        ST_EM_START, ST_WALK_CHK, ST_WALK_EV
    } state_t;

    state_t state_reg;
    logic               out_wait_reg;
    logic [CNT_W-1:0]   cnt_reg, live_reg;
    logic               ovf_reg;
    logic [IDX_W-1:0]   k_reg, sidx_reg, m1_idx_reg, m2_idx_reg;
    logic [WW-1:0]      w1_reg, w2_reg, last_w_reg;
    logic [NODE_W-1:0]  n1_reg, n2_reg, last_n_reg, next_reg, root_reg, node_reg;
    logic               m2v_reg;
    logic [CODE_BITS_W-1:0] code_reg;
    logic [IDX_W-1:0]   len_reg;
    logic [SYMBOL_W-1:0]    o_sym_reg;
    logic [CODE_BITS_W-1:0] o_code_reg;
    logic [CODE_LEN_W-1:0]  o_len_reg;
    logic               o_last_reg;

    logic               slot_we, node_we, sym_we;
    logic [IDX_W-1:0]   slot_waddr;
    logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
    logic [NODE_W-1:0]  node_waddr;
    logic [NODE_W:0]    node_wdata, node_rdata;
    logic [SYMBOL_W-1:0] sym_rdata;
    logic [WW-1:0]      fmask, fin, sum, rd_w;
    logic [NODE_W-1:0]  rd_n;
    logic               accept;
    logic [CNT_W-1:0]   cnt_next;

    assign fmask    = (WW'(1) << FREQ_BITS) - WW'(1);
    assign fin      = WW'(s_tdata[FREQ_IN_W-1:0]) & fmask;
    assign sum      = w1_reg + w2_reg;
    assign rd_w     = slot_rdata[WW-1:0];
    assign rd_n     = slot_rdata[SLOT_W-1:WW];
    assign accept   = s_tvalid && s_tready;
    assign cnt_next = (cnt_reg < CNT_W'(MAX_SYMBOLS)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_wait_reg;
    assign m_tdata  = {{(M_TDATA_W - SYMBOL_W - CODE_BITS_W - CODE_LEN_W){1'b0}},
                       o_len_reg, o_code_reg, o_sym_reg};
    assign m_tuser  = ovf_reg;
    assign m_tlast  = o_last_reg;

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = m1_idx_reg;
        slot_wdata = {next_reg, sum};
        node_we    = 1'b0;
        node_waddr = n1_reg;
        node_wdata = {next_reg, 1'b0};
        sym_we     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (accept && cnt_reg < CNT_W'(MAX_SYMBOLS)) begin
                    slot_we    = 1'b1;
                    sym_we     = 1'b1;
                    slot_waddr = IDX_W'(cnt_reg);
                    slot_wdata = {NODE_W'(cnt_reg), fin};
                end
            end
            ST_MERGE_A: begin
                slot_we = 1'b1;
                node_we = 1'b1;
            end
            ST_MERGE_B: begin
                slot_we    = 1'b1;
                slot_waddr = m2_idx_reg;
                slot_wdata = {last_n_reg, last_w_reg};
                node_we    = 1'b1;
                node_waddr = n2_reg;
                node_wdata = {next_reg, 1'b1};
            end
            default: begin
            end
        endcase
    end

    hcb_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SYMBOLS)) u_slot_ram (
        .aclk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(k_reg), .rdata(slot_rdata)
    );

    hcb_ram #(.WIDTH(NODE_W + 1), .DEPTH(NODES)) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_reg), .rdata(node_rdata)
    );

    hcb_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_SYMBOLS)) u_sym_ram (
        .aclk(aclk), .we(sym_we), .waddr(IDX_W'(cnt_reg)),
        .wdata(s_tdata[FREQ_IN_W +: SYMBOL_W]), .raddr(sidx_reg), .rdata(sym_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            out_wait_reg <= 1'b0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        cnt_reg <= cnt_next;
                        if (cnt_reg == CNT_W'(MAX_SYMBOLS)) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            live_reg <= cnt_next;
                            next_reg <= NODE_W'(cnt_next);
                            k_reg    <= '0;
                            sidx_reg <= '0;
                            root_reg <= '0;
                            state_reg <= (cnt_next > CNT_W'(1)) ? ST_SCAN_RD : ST_EM_START;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP: begin
                    if (k_reg == '0) begin
                        m1_idx_reg <= k_reg;
                        w1_reg     <= rd_w;
                        n1_reg     <= rd_n;
                        m2v_reg    <= 1'b0;
                    end else if (rd_w < w1_reg) begin
                        m2_idx_reg <= m1_idx_reg;
                        w2_reg     <= w1_reg;
                        n2_reg     <= n1_reg;
                        m2v_reg    <= 1'b1;
                        m1_idx_reg <= k_reg;
                        w1_reg     <= rd_w;
                        n1_reg     <= rd_n;
                    end else if (!m2v_reg || rd_w < w2_reg) begin
                        m2_idx_reg <= k_reg;
                        w2_reg     <= rd_w;
                        n2_reg     <= rd_n;
                        m2v_reg    <= 1'b1;
                    end
                    if (k_reg == IDX_W'(live_reg - CNT_W'(1))) begin
                        last_w_reg <= rd_w;
                        last_n_reg <= rd_n;
                        state_reg  <= ST_MERGE_A;
                    end else begin
                        k_reg     <= k_reg + IDX_W'(1);
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_MERGE_A: begin
                    if (m1_idx_reg == IDX_W'(live_reg - CNT_W'(1))) begin
                        last_w_reg <= sum;
                        last_n_reg <= next_reg;
                    end
                    state_reg <= ST_MERGE_B;
                end
                ST_MERGE_B: begin
                    live_reg <= live_reg - CNT_W'(1);
                    next_reg <= next_reg + NODE_W'(1);
                    k_reg    <= '0;
                    if (live_reg == CNT_W'(2)) begin
                        root_reg  <= next_reg;
                        state_reg <= ST_EM_START;
                    end else begin
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_EM_START: begin
                    node_reg  <= NODE_W'(sidx_reg);
                    code_reg  <= '0;
                    len_reg   <= '0;
                    state_reg <= ST_WALK_CHK;
                end
                ST_WALK_CHK: begin
                    if (out_wait_reg) begin
                        if (m_tready) begin
                            out_wait_reg <= 1'b0;
                            if (o_last_reg) begin
                                cnt_reg   <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= ST_LOAD;
                            end else begin
                                sidx_reg  <= sidx_reg + IDX_W'(1);
                                state_reg <= ST_EM_START;
                            end
                        end
                    end else if (node_reg == root_reg) begin
                        out_wait_reg <= 1'b1;
                        o_sym_reg    <= sym_rdata;
                        o_code_reg   <= code_reg;
                        o_len_reg    <= CODE_LEN_W'(len_reg);
                        o_last_reg   <= (sidx_reg == IDX_W'(cnt_reg - CNT_W'(1)));
                    end else begin
                        state_reg <= ST_WALK_EV;
                    end
                end
                ST_WALK_EV: begin
                    if (32'(len_reg) < CODE_BITS_W) begin
                        code_reg[len_reg[$clog2(CODE_BITS_W)-1:0]] <= node_rdata[0];
                    end
                    len_reg   <= len_reg + IDX_W'(1);
                    node_reg  <= node_rdata[NODE_W:1];
                    state_reg <= ST_WALK_CHK;
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SYMBOLS))
        else $error("symbol count beyond capacity");

    a_scan_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_CMP) |-> (live_reg >= CNT_W'(2)))
        else $error("merge pass with fewer than two live slots");

    a_out_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cnt_reg != '0))
        else $error("result word with empty set");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import hcb_pkg::*;

    localparam int NSYM      = DEF_MAX_SYMBOLS;
    localparam int NNODE     = 2 * NSYM - 1;
    localparam int LIMIT     = 600000;
    localparam int HOLD_FROM = 3000;
    localparam int HOLD_LEN  = 1500;

    typedef struct packed {
        logic [FREQ_IN_W-1:0] freq;
        logic [SYMBOL_W-1:0]  sym;
        logic                 last;
        logic                 drain;
        logic [1:0]           phase;
    } sym_word_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0]    sym;
        logic [CODE_BITS_W-1:0] code;
        logic [CODE_LEN_W-1:0]  len;
        logic                   ovf;
        logic                   lst;
    } code_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    sym_word_t  pending_q[$];
    code_word_t code_q[$];
    sym_word_t  cur_word;
    logic [1:0] cur_phase = 2'd0;
    int         errors = 0;
    int         cycle = 0;
    int         sets_sent = 0;
    int         words_seen = 0;

    // predictor state
    longint unsigned leaf_w[NSYM];
    logic [7:0]      sym_mem[NSYM];
    int              n_loaded = 0;
    bit              ovf_seen = 0;

    huffman_code_builder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic int tx_idle_pct(logic [1:0] ph);
        return (ph == 2'd1) ? 59 : (ph == 2'd3) ? 35 : 0;
    endfunction

    function automatic int rx_idle_pct(logic [1:0] ph);
        return (ph == 2'd2) ? 59 : (ph == 2'd3) ? 35 : 0;
    endfunction

    task automatic build_codes();
        int              slot_n[NSYM];
        longint unsigned slot_w[NSYM];
        int              parent[NNODE];
        bit              branch[NNODE];
        int              live, nxt, m1, m2, root, node, len;
        logic [63:0]     code;
        code_word_t      cw;
        live = n_loaded;
        nxt = n_loaded;
        for (int i = 0; i < n_loaded; i++) begin
            slot_n[i] = i;
            slot_w[i] = leaf_w[i];
        end
        while (live > 1 && nxt < NNODE) begin
            m1 = 0;
            m2 = 1;
            if (slot_w[1] < slot_w[0]) begin
                m1 = 1;
                m2 = 0;
            end
            for (int k = 2; k < live; k++) begin
                if (slot_w[k] < slot_w[m1]) begin
                    m2 = m1;
                    m1 = k;
                end else if (slot_w[k] < slot_w[m2]) begin
                    m2 = k;
                end
            end
            parent[slot_n[m1]] = nxt;
            branch[slot_n[m1]] = 1'b0;
            parent[slot_n[m2]] = nxt;
            branch[slot_n[m2]] = 1'b1;
            slot_w[m1] = slot_w[m1] + slot_w[m2];
            slot_n[m1] = nxt;
            slot_n[m2] = slot_n[live-1];
            slot_w[m2] = slot_w[live-1];
            live--;
            nxt++;
        end
        root = slot_n[0];
        for (int s = 0; s < n_loaded; s++) begin
            code = '0;
            len = 0;
            node = s;
            while (node != root && len < NSYM && node < NNODE) begin
                code[len] = branch[node];
                len++;
                node = parent[node];
            end
            cw.sym  = sym_mem[s];
            cw.code = code[CODE_BITS_W-1:0];
            cw.len  = len[CODE_LEN_W-1:0];
            cw.ovf  = ovf_seen;
            cw.lst  = (s + 1 == n_loaded);
            code_q.push_back(cw);
        end
        n_loaded = 0;
        ovf_seen = 0;
    endtask

    task automatic load_word(sym_word_t w);
        if (n_loaded < NSYM) begin
            leaf_w[n_loaded] = w.freq;
            sym_mem[n_loaded] = w.sym;
            n_loaded++;
        end else begin
            ovf_seen = 1;
        end
        if (w.last)
            build_codes();
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                load_word(cur_word);
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() == 0 ||
                    (pending_q[0].drain && code_q.size() != 0) ||
                    $urandom_range(99) < tx_idle_pct(pending_q[0].phase)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    cur_word = pending_q.pop_front();
                    cur_phase <= cur_word.phase;
                    s_tdata <= {cur_word.sym, cur_word.freq};
                    s_tlast <= cur_word.last;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        code_word_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (code_q.size() == 0) begin
                    $error("unexpected word: symbol %0d", m_tdata[7:0]);
                    errors++;
                end else begin
                    want = code_q.pop_front();
                    if (m_tdata[7:0] !== want.sym) begin
                        $error("symbol_out: expected %0d got %0d", want.sym, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[22:8] !== want.code) begin
                        $error("code_bits: expected %0h got %0h", want.code, m_tdata[22:8]);
                        errors++;
                    end
                    if (m_tdata[26:23] !== want.len) begin
                        $error("code_length: expected %0d got %0d", want.len, m_tdata[26:23]);
                        errors++;
                    end
                    if (m_tuser !== want.ovf) begin
                        $error("overflow: expected %0b got %0b", want.ovf, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.lst) begin
                        $error("last_out: expected %0b got %0b", want.lst, m_tlast);
                        errors++;
                    end
                end
            end
        end
        if (cycle >= HOLD_FROM && cycle < HOLD_FROM + HOLD_LEN)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct(cur_phase));
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic add_word(int freq, int sym, bit last, bit drain, int ph);
        sym_word_t w;
        w.freq  = freq[FREQ_IN_W-1:0];
        w.sym   = sym[SYMBOL_W-1:0];
        w.last  = last;
        w.drain = drain;
        w.phase = ph[1:0];
        pending_q.push_back(w);
    endtask

    initial begin
        int n, ph, total, f0, f1, f2, mode;
        // lone symbols, smallest and largest fields
        add_word(0, 0, 1, 0, 0);
        add_word(65535, 255, 1, 0, 0);
        // equal weights, ties go to the lower slot
        add_word(7, 1, 0, 0, 0);
        add_word(7, 2, 1, 0, 0);
        add_word(5, 10, 0, 0, 0);
        add_word(5, 11, 0, 0, 0);
        add_word(5, 12, 1, 0, 0);
        // fibonacci weights for the deepest tree, then words past capacity
        f0 = 1;
        f1 = 1;
        for (int i = 0; i < 17; i++) begin
            add_word((i < NSYM) ? f0 : 65535, 100 + i, i == 16, 0, 0);
            f2 = f0 + f1;
            f0 = f1;
            f1 = f2;
        end
        total = pending_q.size();
        sets_sent = 5;
        while (total < 370) begin
            ph = (sets_sent / 3) % 4;
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
            mode = $urandom_range(3);
            for (int i = 0; i < n; i++)
                add_word(mode == 0 ? $urandom_range(3) :
                         mode == 1 ? $urandom_range(40) : $urandom_range(65535),
                         $urandom_range(255), i == n - 1, i == 0 && sets_sent % 7 == 0, ph);
            total += n;
            sets_sent++;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // sample away from the active edge so driver updates have settled
        while (pending_q.size() != 0 || s_tvalid || code_q.size() != 0)
            @(negedge aclk);
        repeat (400) @(posedge aclk);
        $display("covered %0d symbol sets (%0d input words), %0d code words checked",
                 sets_sent, total, words_seen);
        $display("lone symbols, ties, deepest tree, overflow, four handshake idle mixes");
        if (errors == 0 && code_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
